### design/eam_pkg.sv
`timescale 1ns / 1ps
package eam_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int MAX_CPUS    = 16;

   localparam int ADDR_W  = 32;
   localparam int WORD_W  = ADDR_W - 2;
   localparam int CPU_W   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
   localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int NCPU_W  = 5;

   localparam logic [ADDR_W-1:0] WORD_MASK = 32'hFFFF_FFFC;

   localparam logic [1:0] CMD_MARK  = 2'd0;
   localparam logic [1:0] CMD_TEST  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_CLEAR_MISS = 2'd1;
   localparam logic [1:0] ST_OVER_CPUS  = 2'd2;
   localparam logic [1:0] ST_FULL       = 2'd3;

   localparam logic [NCPU_W-1:0] NUM_CPUS_RESET = 5'd4;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [CPU_W-1:0]  owner;
   } eam_entry_type;

   typedef struct packed {
      logic live;
      logic load;
      logic shift;
   } eam_ctrl_type;

endpackage

### design/eam_cell.sv
`timescale 1ns / 1ps
module eam_cell (
   input  logic                   clock,
   input  eam_pkg::eam_ctrl_type  ctrl,
   input  logic [eam_pkg::WORD_W-1:0] word,
   input  logic [eam_pkg::CPU_W-1:0]  cpu,
   input  eam_pkg::eam_entry_type next_entry,
   input  logic                   hit_in,
   input  logic                   own_ok_in,
   output eam_pkg::eam_entry_type entry_out,
   output logic                   hit_out,
   output logic                   own_ok_out
);
   import eam_pkg::*;

   eam_entry_type entry_ff;
   eam_entry_type entry_in;
   logic          match;

   assign match      = ctrl.live && (entry_ff.word == word);
   assign hit_out    = hit_in || match;
   assign own_ok_out = hit_in ? own_ok_in : (match && (entry_ff.owner == cpu));
   assign entry_out  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in.word  = word;
         entry_in.owner = cpu;
      end else if (ctrl.shift && hit_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### design/exclusive_access_monitor.sv
`timescale 1ns / 1ps
// exclusive access monitor: table of reserved word addresses with owning cpu
// request channel (req_*): command, cpu_id and byte address, valid/ready
// response channel (rsp_*): exclusive_fail and status, valid/ready
// csr port: csr_write_enable / csr_write_data set num_cpus, write when idle
// each request beat gives exactly one response beat, registered, in the cycle after accept
// throughput is one beat per cycle while rsp_ready drains each response:
// every table cell compares its entry in parallel and the first-match flag
// ripples along the row of cells, so a mark, test or clear (with
// shift-down of later entries) completes in the accept cycle
// the response sits in an output register; while it waits, a new request
// is taken only in a cycle where rsp_ready drains the old one
// reset (synchronous, active high) empties the table and sets num_cpus to 4;
// the table entries themselves are not cleared, the fill count guards them
module exclusive_access_monitor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic [3:0]                    req_cpu_id,
   input  logic [31:0]                   req_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_exclusive_fail,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_write_enable,
   input  logic [eam_pkg::NCPU_W-1:0]    csr_write_data
);
   import eam_pkg::*;

   logic [NCPU_W-1:0]  num_cpus_ff;
   logic [COUNT_W-1:0] used_ff;
   logic [COUNT_W-1:0] used_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               fail_ff;
   logic               fail_in;
   logic [1:0]         status_ff;
   logic [1:0]         status_in;

   logic               accept;
   logic [WORD_W-1:0]  word;
   logic [CPU_W-1:0]   cpu;
   logic               full;
   logic               append;
   logic [COUNT_W-1:0] used_plus;
   logic               hit;

   logic               hit_chain [TABLE_DEPTH+1];
   logic               own_chain [TABLE_DEPTH+1];
   eam_entry_type      entries   [TABLE_DEPTH];
   eam_ctrl_type       ctrl      [TABLE_DEPTH];

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign word      = WORD_W'((req_address & WORD_MASK) >> 2);
   assign cpu       = CPU_W'(req_cpu_id);
   assign full      = (used_ff >= COUNT_W'(TABLE_DEPTH));
   assign hit       = hit_chain[TABLE_DEPTH];
   assign append    = accept && (req_command == CMD_MARK) && !hit && !full;
   assign used_plus = used_ff + COUNT_W'(1);

   assign hit_chain[0] = 1'b0;
   assign own_chain[0] = 1'b0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      eam_entry_type next_entry;

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign next_entry = entries[i];
      end else begin : g_mid
         assign next_entry = entries[i+1];
      end

      assign ctrl[i].live  = (COUNT_W'(i) < used_ff);
      assign ctrl[i].load  = append && (used_ff == COUNT_W'(i));
      assign ctrl[i].shift = accept && (req_command == CMD_CLEAR);

      eam_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[i]),
         .word       (word),
         .cpu        (cpu),
         .next_entry (next_entry),
         .hit_in     (hit_chain[i]),
         .own_ok_in  (own_chain[i]),
         .entry_out  (entries[i]),
         .hit_out    (hit_chain[i+1]),
         .own_ok_out (own_chain[i+1])
      );
   end

   always_comb begin
      used_in   = used_ff;
      fail_in   = fail_ff;
      status_in = status_ff;
      if (accept) begin
         fail_in   = 1'b0;
         status_in = ST_OK;
         case (req_command)
            CMD_MARK: begin
               if (!hit) begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     used_in = used_plus;
                     if ({{(7-COUNT_W){1'b0}}, used_plus} >
                         ({2'b00, num_cpus_ff} + 7'd1)) begin
                        status_in = ST_OVER_CPUS;
                     end
                  end
               end
            end
            CMD_TEST: begin
               fail_in = !(hit && own_chain[TABLE_DEPTH]);
            end
            CMD_CLEAR: begin
               if (hit) begin
                  used_in = used_ff - COUNT_W'(1);
               end else begin
                  status_in = ST_CLEAR_MISS;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cpus_ff  <= NUM_CPUS_RESET;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            num_cpus_ff <= csr_write_data;
         end
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fail_ff   <= fail_in;
      status_ff <= status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_exclusive_fail = fail_ff;
   assign rsp_status         = status_ff;

`ifndef NO_ASSERTIONS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= COUNT_W'(TABLE_DEPTH))
      else $error("table count beyond depth");

   a_drop_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_MARK) && full && !hit)
      |=> (used_ff == $past(used_ff)) && (rsp_status == ST_FULL))
      else $error("dropped mark changed the table");

   a_clear_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_CLEAR) && hit)
      |=> (used_ff == $past(used_ff) - COUNT_W'(1)))
      else $error("clear hit did not remove an entry");

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat gave no response");
`endif

endmodule
